FILE: sv/lpsc_pkg.sv
// shared types and constants of the length-prefix to start-code converter
package lpsc_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  localparam logic [1:0] PrefixReset  = 2'd3;
  localparam logic [7:0] StartCodeEnd = 8'h01;
  localparam logic [7:0] StartCodePad = 8'h00;
  localparam logic [4:0] TypeMask     = 5'h1f;
  localparam logic [0:0] RegPrefixIdx = 1'b0;

  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_START,
    CMD_DATA
  } lpsc_kind_e;

  typedef struct packed {
    lpsc_kind_e  kind;
    logic [7:0]  data_byte;
    logic [4:0]  unit_type;
    logic        sample_done;
    logic        sample_status;
  } lpsc_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpsc_fifo_stat_t;

endpackage

FILE: sv/lpsc_front.sv
// front part: parses length prefixes and classifies each input word into a command
module lpsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          prefix_bytes_minus_one_i,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                sample_last_i,
  output logic                push_o,
  output lpsc_pkg::lpsc_cmd_t cmd_o
);

  logic        in_payload_q, in_payload_d;
  logic        first_q, first_d;
  logic [1:0]  prefix_count_q, prefix_count_d;
  logic [31:0] length_accum_q, length_accum_d;
  logic [31:0] payload_left_q, payload_left_d;
  logic [4:0]  current_type_q, current_type_d;
  logic [31:0] accum_next;
  logic [4:0]  type_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q   <= 1'b0;
      first_q        <= 1'b0;
      prefix_count_q <= 2'd0;
      length_accum_q <= 32'd0;
      payload_left_q <= 32'd0;
      current_type_q <= 5'd0;
    end else begin
      in_payload_q   <= in_payload_d;
      first_q        <= first_d;
      prefix_count_q <= prefix_count_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      current_type_q <= current_type_d;
    end
  end

  always_comb begin
    in_payload_d   = in_payload_q;
    first_d        = first_q;
    prefix_count_d = prefix_count_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    current_type_d = current_type_q;
    push_o         = 1'b0;
    cmd_o          = '{kind: lpsc_pkg::CMD_STATUS, data_byte: 8'd0, unit_type: 5'd0,
                       sample_done: 1'b0, sample_status: 1'b0};
    accum_next     = {length_accum_q[23:0], data_byte_i};
    type_now       = first_q ? (data_byte_i[4:0] & lpsc_pkg::TypeMask) : current_type_q;

    if (accept_i) begin
      if (in_payload_q) begin
        push_o              = 1'b1;
        cmd_o.kind          = lpsc_pkg::CMD_DATA;
        cmd_o.data_byte     = data_byte_i;
        cmd_o.unit_type     = type_now;
        cmd_o.sample_done   = sample_last_i;
        cmd_o.sample_status = sample_last_i && (payload_left_q != 32'd1);
        if (sample_last_i || payload_left_q == 32'd1) begin
          in_payload_d   = 1'b0;
          first_d        = 1'b0;
          prefix_count_d = 2'd0;
          length_accum_d = 32'd0;
          payload_left_d = 32'd0;
          current_type_d = 5'd0;
        end else begin
          first_d        = 1'b0;
          payload_left_d = payload_left_q - 32'd1;
          current_type_d = type_now;
        end
      end else if (prefix_count_q >= prefix_bytes_minus_one_i) begin
        push_o         = 1'b1;
        prefix_count_d = 2'd0;
        length_accum_d = 32'd0;
        if (sample_last_i) begin
          cmd_o.kind        = lpsc_pkg::CMD_STATUS;
          cmd_o.sample_done = 1'b1;
        end else begin
          cmd_o.kind = lpsc_pkg::CMD_START;
          if (accum_next != 32'd0) begin
            in_payload_d   = 1'b1;
            first_d        = 1'b1;
            payload_left_d = accum_next;
          end
        end
      end else if (sample_last_i) begin
        push_o            = 1'b1;
        cmd_o.kind        = lpsc_pkg::CMD_STATUS;
        cmd_o.sample_done = 1'b1;
        prefix_count_d    = 2'd0;
        length_accum_d    = 32'd0;
      end else begin
        prefix_count_d = prefix_count_q + 2'd1;
        length_accum_d = accum_next;
      end
    end
  end

endmodule

FILE: sv/lpsc_fifo.sv
// short command queue between front and back parts
module lpsc_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  lpsc_pkg::lpsc_cmd_t       push_cmd_i,
  input  logic                      pop_i,
  output lpsc_pkg::lpsc_cmd_t       head_o,
  output lpsc_pkg::lpsc_fifo_stat_t stat_o
);

  localparam int unsigned Aw = lpsc_pkg::FifoAw;

  lpsc_pkg::lpsc_cmd_t mem_q [lpsc_pkg::FifoDepth];
  logic [Aw-1:0] wr_ptr_q, wr_ptr_d;
  logic [Aw-1:0] rd_ptr_q, rd_ptr_d;
  logic [Aw:0]   count_q, count_d;
  logic          do_push, do_pop;

  assign stat_o.full  = (count_q == Aw'(0) + (Aw+1)'(lpsc_pkg::FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + Aw'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + Aw'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (Aw+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (Aw+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: sv/lpsc_back.sv
// back part: expands commands into output words behind an output register
module lpsc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  lpsc_pkg::lpsc_cmd_t head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  output logic [7:0]          m_axis_tuser_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_last_q, out_last_d;
  logic [7:0] out_user_q, out_user_d;
  logic [1:0] beat_q, beat_d;
  logic       load;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  always_comb begin
    load        = head_valid_i && (!out_valid_q || m_axis_tready_i);
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    beat_d      = beat_q;
    pop_o       = 1'b0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    if (load) begin
      out_valid_d = 1'b1;
      case (head_i.kind)
        lpsc_pkg::CMD_START: begin
          out_data_d = (beat_q == 2'd3) ? lpsc_pkg::StartCodeEnd : lpsc_pkg::StartCodePad;
          out_last_d = (beat_q == 2'd3);
          out_user_d = {1'b0, 1'b0, 5'd0, 1'b1};
          pop_o      = (beat_q == 2'd3);
          beat_d     = beat_q + 2'd1;
        end
        lpsc_pkg::CMD_DATA: begin
          out_data_d = head_i.data_byte;
          out_last_d = 1'b1;
          out_user_d = {head_i.sample_status, head_i.sample_done, head_i.unit_type, 1'b1};
          pop_o      = 1'b1;
          beat_d     = 2'd0;
        end
        default: begin
          out_data_d = 8'd0;
          out_last_d = 1'b1;
          out_user_d = {1'b0, 1'b1, 5'd0, 1'b0};
          pop_o      = 1'b1;
          beat_d     = 2'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= 2'd0;
    end else begin
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

endmodule

FILE: sv/length_prefix_to_start_code.sv
// top level of the length-prefix to start-code converter
//
// input stream: one sample byte per word on s_axis, tlast on the sample's final byte
// output stream: start code and payload bytes on m_axis, one byte per word;
//   tlast closes the words caused by one input word, tuser carries byte_valid,
//   unit_type, sample_done and sample_status
// apb register 0: prefix_bytes_minus_one (reset 3), write only while idle
// each input word is classified combinationally, and the command it yields, if any, is
// queued in the same cycle; a completed prefix becomes four start code words, a payload
// byte one word, and a dropped prefix at the end of a sample one status word with no byte
// path: an input word's command is written into the queue, then loaded into the output register
// throughput: one input word per cycle while the queue has room and the output takes
//   one word per cycle; each start code goes out as four words through the single output
//   register, and the four-entry queue absorbs those bursts
// reset clears the parser, the queue and the output register; the prefix
//   size returns to four bytes
// when the receiver stalls the output word holds, the queue fills and
//   s_axis_tready drops once all four entries are taken
module length_prefix_to_start_code (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,
  output logic [7:0]  m_axis_tuser    // byte_valid, unit_type[4:0], sample_done, sample_status
);

  logic [1:0]                prefix_q, prefix_d;
  logic                      cfg_write;
  logic                      accept;
  logic                      push;
  logic                      pop;
  lpsc_pkg::lpsc_cmd_t       push_cmd;
  lpsc_pkg::lpsc_cmd_t       head;
  lpsc_pkg::lpsc_fifo_stat_t fifo_stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == lpsc_pkg::RegPrefixIdx);
  assign prefix_d  = cfg_write ? pwdata[1:0] : prefix_q;
  assign prdata    = (paddr[2] == lpsc_pkg::RegPrefixIdx) ? {30'd0, prefix_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q <= lpsc_pkg::PrefixReset;
    end else begin
      prefix_q <= prefix_d;
    end
  end

  assign s_axis_tready = !fifo_stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lpsc_front u_front (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .prefix_bytes_minus_one_i (prefix_q),
    .accept_i                 (accept),
    .data_byte_i              (s_axis_tdata),
    .sample_last_i            (s_axis_tlast),
    .push_o                   (push),
    .cmd_o                    (push_cmd)
  );

  lpsc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (fifo_stat)
  );

  lpsc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!fifo_stat.empty),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // a status word without a byte always ends its run and its sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[6] &&
      m_axis_tdata == 8'd0 && !m_axis_tuser[7])
    else $error("status word malformed");

  // truncation is only reported on a sample's final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[7] |-> m_axis_tuser[6] && m_axis_tlast)
    else $error("truncation flag without sample end");

  // a word the queue cannot take is never pushed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_stat.full)
    else $error("push into full queue");

endmodule
